// File: rtl/sample_state_histogram_core_defines.svh
// Assertion macros shared by the sample state histogram RTL.
`ifndef SAMPLE_STATE_HISTOGRAM_CORE_DEFINES_SVH
`define SAMPLE_STATE_HISTOGRAM_CORE_DEFINES_SVH

// Same-cycle implication, sampled on clk, off during reset.
`define SSH_ASSERT_IMP(label, ante, cons) \
	label: assert property (@(posedge clk) disable iff (!arst_n) (ante) |-> (cons)) \
		else $error("sshist: check failed");

// Next-cycle implication, sampled on clk, off during reset.
`define SSH_ASSERT_NXT(label, ante, cons) \
	label: assert property (@(posedge clk) disable iff (!arst_n) (ante) |=> (cons)) \
		else $error("sshist: check failed");

`endif

// File: rtl/sshist_pkg.sv
// Types and constants of the sample state histogram.
`default_nettype none

package sshist_pkg;

	localparam int WORD_W    = 64;
	localparam int STAT_W    = 48;
	localparam int PKT_W     = 32;
	localparam int TALLY_W   = 7;
	localparam int CHAN_W    = 7;
	localparam int MODE_W    = 2;
	localparam int CFG_IDX_W = 2;
	localparam int EXT_W     = 64;
	localparam int SLOTS_ONE = 64;
	localparam int SLOTS_TWO = 32;
	localparam int NUM_STATES = 4;

	localparam int OBUF_DEPTH = 4;
	localparam int OBUF_PTR_W = 2;
	localparam int OBUF_CNT_W = 3;

	localparam logic [STAT_W-1:0] STAT_MAX = {STAT_W{1'b1}};
	localparam logic [PKT_W-1:0]  PKT_MAX  = {PKT_W{1'b1}};

	typedef enum logic [MODE_W-1:0] {
		MODE_NONE = 2'd0,
		MODE_ONE  = 2'd1,
		MODE_TWO  = 2'd2,
		MODE_OFF  = 2'd3
	} mode_t;

	typedef enum logic [CFG_IDX_W-1:0] {
		REG_BITS_PER_SAMPLE = 2'd0,
		REG_SLOT_MASK       = 2'd1,
		REG_CHANNEL_COUNT   = 2'd2
	} cfg_reg_t;

	typedef struct packed {
		logic [MODE_W-1:0] bits_per_sample;
		logic [WORD_W-1:0] slot_mask;
		logic [CHAN_W-1:0] channel_count;
	} cfg_t;

	typedef struct packed {
		logic                                active;
		logic [NUM_STATES-1:0][TALLY_W-1:0]  tally;
		logic [TALLY_W-1:0]                  inc;
	} tally_t;

	typedef struct packed {
		logic [STAT_W-1:0] count_state0;
		logic [STAT_W-1:0] count_state1;
		logic [STAT_W-1:0] count_state2;
		logic [STAT_W-1:0] count_state3;
		logic [STAT_W-1:0] sample_total;
		logic [PKT_W-1:0]  packet_total;
	} stat_t;

endpackage

`default_nettype wire

// File: rtl/sshist_if.sv
// Word, statistics and configuration channels of the sample state histogram.
`default_nettype none

interface sshist_word_if;
	logic                      valid;
	logic                      ready;
	logic [sshist_pkg::WORD_W-1:0] data_word;
	logic                      last_word;

	modport source(output valid, output data_word, output last_word, input ready);
	modport sink(input valid, input data_word, input last_word, output ready);
endinterface

interface sshist_stat_if;
	logic                          valid;
	logic                          ready;
	logic [sshist_pkg::STAT_W-1:0] count_state0;
	logic [sshist_pkg::STAT_W-1:0] count_state1;
	logic [sshist_pkg::STAT_W-1:0] count_state2;
	logic [sshist_pkg::STAT_W-1:0] count_state3;
	logic [sshist_pkg::STAT_W-1:0] sample_total;
	logic [sshist_pkg::PKT_W-1:0]  packet_total;

	modport source(output valid, output count_state0, output count_state1,
		output count_state2, output count_state3, output sample_total,
		output packet_total, input ready);
	modport sink(input valid, input count_state0, input count_state1,
		input count_state2, input count_state3, input sample_total,
		input packet_total, output ready);
endinterface

interface sshist_cfg_if;
	logic                             valid;
	logic                             ready;
	logic [sshist_pkg::CFG_IDX_W-1:0] index;
	logic [sshist_pkg::WORD_W-1:0]    data;

	modport source(output valid, output index, output data, input ready);
	modport sink(input valid, input index, input data, output ready);
endinterface

`default_nettype wire

// File: rtl/sample_state_histogram_core.sv
// Top level of the sample state histogram.
//
// Usage:
//   samples : 64-bit data words with a last-word flag, valid/ready.
//   stats   : one result per last word: four state counts, sample total and
//             packet total, all including that word; valid/ready.
//   cfg     : register writes (index 0 bits per sample, 1 slot mask,
//             2 channel count), always ready; write only while idle.
// Timing: a word is registered, tallied in the next cycle and accumulated
// in the one after, when its result is written to the queue that feeds stats.
// One word per cycle is taken while the four-entry result queue, counted
// together with words still in the two-stage pipeline, has room; with stats
// ready the block runs at one word per cycle.
// Reset clears all counters, the pipeline and the queue and restores the
// registers to 2-bit mode, empty mask and channel count zero.
// When stats stalls, results wait in the queue; samples.ready drops once
// the queue plus words in flight reach four.
`default_nettype none
`include "sample_state_histogram_core_defines.svh"

module sample_state_histogram_core #(
	parameter int COUNTER_WIDTH = 48
) (
	input  logic           clk,
	input  logic           arst_n,
	sshist_word_if.sink    samples,
	sshist_stat_if.source  stats,
	sshist_cfg_if.sink     cfg
);
	import sshist_pkg::*;

	localparam logic [COUNTER_WIDTH-1:0] CNT_MAX = {COUNTER_WIDTH{1'b1}};

	cfg_t                     cfg_q;
	logic [WORD_W-1:0]        word_s1;
	logic                     last_s1;
	logic                     valid_s1;
	tally_t                   tally;
	tally_t                   tally_s2;
	logic                     last_s2;
	logic                     valid_s2;
	logic [COUNTER_WIDTH-1:0] bin_q [NUM_STATES];
	logic [COUNTER_WIDTH-1:0] bin_nxt [NUM_STATES];
	logic [COUNTER_WIDTH-1:0] samples_q;
	logic [COUNTER_WIDTH-1:0] samples_nxt;
	logic [PKT_W-1:0]         packets_q;
	logic [PKT_W-1:0]         packets_nxt;
	logic [OBUF_CNT_W-1:0]    obuf_cnt;
	logic [OBUF_CNT_W-1:0]    occ;
	logic                     accept;
	logic                     push;
	logic                     bins_idle;
	stat_t                    push_data;

	function automatic logic [COUNTER_WIDTH-1:0] sat_add(
		input logic [COUNTER_WIDTH-1:0] a,
		input logic [TALLY_W-1:0]       b
	);
		logic [COUNTER_WIDTH:0] sum;
		sum = {1'b0, a} + (COUNTER_WIDTH+1)'(b);
		sat_add = sum[COUNTER_WIDTH] ? CNT_MAX : sum[COUNTER_WIDTH-1:0];
	endfunction

	function automatic logic [STAT_W-1:0] clamp_out(input logic [COUNTER_WIDTH-1:0] v);
		logic [EXT_W-1:0] ext;
		ext = EXT_W'(v);
		clamp_out = (ext > EXT_W'(STAT_MAX)) ? STAT_MAX : ext[STAT_W-1:0];
	endfunction

	assign cfg.ready = 1'b1;

	assign occ = obuf_cnt + OBUF_CNT_W'(valid_s1) + OBUF_CNT_W'(valid_s2);
	assign samples.ready = (occ < OBUF_CNT_W'(OBUF_DEPTH));
	assign accept = samples.valid && samples.ready;

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			cfg_q.bits_per_sample <= MODE_TWO;
			cfg_q.slot_mask       <= '0;
			cfg_q.channel_count   <= '0;
		end else if (cfg.valid) begin
			case (cfg.index)
				REG_BITS_PER_SAMPLE: cfg_q.bits_per_sample <= cfg.data[MODE_W-1:0];
				REG_SLOT_MASK:       cfg_q.slot_mask       <= cfg.data;
				REG_CHANNEL_COUNT:   cfg_q.channel_count   <= cfg.data[CHAN_W-1:0];
				default: ;
			endcase
		end
	end

	sshist_tally u_tally (
		.word  (word_s1),
		.cfg   (cfg_q),
		.tally (tally)
	);

	always_ff @(posedge clk) begin
		if (accept) begin
			word_s1 <= samples.data_word;
			last_s1 <= samples.last_word;
		end
		tally_s2 <= tally;
		last_s2  <= last_s1;
	end

	always_comb begin
		for (int k = 0; k < NUM_STATES; k++) begin
			bin_nxt[k] = bin_q[k];
		end
		samples_nxt = samples_q;
		packets_nxt = packets_q;
		if (valid_s2 && tally_s2.active) begin
			for (int k = 0; k < NUM_STATES; k++) begin
				bin_nxt[k] = sat_add(bin_q[k], tally_s2.tally[k]);
			end
			samples_nxt = sat_add(samples_q, tally_s2.inc);
		end
		if (valid_s2 && last_s2 && (packets_q != PKT_MAX)) begin
			packets_nxt = packets_q + 1'b1;
		end
	end

	assign push = valid_s2 && last_s2;

	always_comb begin
		push_data.count_state0 = clamp_out(bin_nxt[0]);
		push_data.count_state1 = clamp_out(bin_nxt[1]);
		push_data.count_state2 = clamp_out(bin_nxt[2]);
		push_data.count_state3 = clamp_out(bin_nxt[3]);
		push_data.sample_total = clamp_out(samples_nxt);
		push_data.packet_total = packets_nxt;
	end

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			valid_s1  <= 1'b0;
			valid_s2  <= 1'b0;
			samples_q <= '0;
			packets_q <= '0;
			for (int k = 0; k < NUM_STATES; k++) begin
				bin_q[k] <= '0;
			end
		end else begin
			valid_s1  <= accept;
			valid_s2  <= valid_s1;
			samples_q <= samples_nxt;
			packets_q <= packets_nxt;
			for (int k = 0; k < NUM_STATES; k++) begin
				bin_q[k] <= bin_nxt[k];
			end
		end
	end

	sshist_obuf u_obuf (
		.clk       (clk),
		.arst_n    (arst_n),
		.push      (push),
		.push_data (push_data),
		.cnt       (obuf_cnt),
		.stats     (stats)
	);

	assign bins_idle = !(valid_s2 && tally_s2.active);

	`SSH_ASSERT_IMP(a_result_has_packet, stats.valid, stats.packet_total != '0)
	`SSH_ASSERT_NXT(a_samples_monotonic, 1'b1, samples_q >= $past(samples_q))
	`SSH_ASSERT_NXT(a_bins_lo_hold, bins_idle, $stable(bin_q[0]) && $stable(bin_q[1]))
	`SSH_ASSERT_NXT(a_bins_hi_hold, bins_idle, $stable(bin_q[2]) && $stable(bin_q[3]))

endmodule

`default_nettype wire

// File: rtl/sshist_tally.sv
// Per-word tally of selected samples by state value.
`default_nettype none

module sshist_tally (
	input  logic [sshist_pkg::WORD_W-1:0] word,
	input  sshist_pkg::cfg_t              cfg,
	output sshist_pkg::tally_t            tally
);
	import sshist_pkg::*;

	logic [WORD_W-1:0] hit [NUM_STATES];
	logic              all_sel;
	logic              sel;

	assign all_sel = (cfg.channel_count == '0);

	always_comb begin
		for (int k = 0; k < NUM_STATES; k++) begin
			hit[k] = '0;
		end
		sel = 1'b0;
		if (cfg.bits_per_sample == MODE_TWO) begin
			for (int s = 0; s < SLOTS_TWO; s++) begin
				sel = all_sel || cfg.slot_mask[s];
				for (int k = 0; k < NUM_STATES; k++) begin
					hit[k][s] = sel && (word[2*s +: 2] == 2'(k));
				end
			end
		end else if (cfg.bits_per_sample == MODE_ONE) begin
			for (int s = 0; s < SLOTS_ONE; s++) begin
				sel = all_sel || cfg.slot_mask[s];
				hit[0][s] = sel && !word[s];
				hit[1][s] = sel && word[s];
			end
		end
	end

	always_comb begin
		tally.active = (cfg.bits_per_sample == MODE_ONE) ||
			(cfg.bits_per_sample == MODE_TWO);
		for (int k = 0; k < NUM_STATES; k++) begin
			tally.tally[k] = TALLY_W'($countones(hit[k]));
		end
		if (!all_sel) begin
			tally.inc = cfg.channel_count;
		end else if (cfg.bits_per_sample == MODE_TWO) begin
			tally.inc = TALLY_W'(SLOTS_TWO);
		end else begin
			tally.inc = TALLY_W'(SLOTS_ONE);
		end
	end

endmodule

`default_nettype wire

// File: rtl/sshist_obuf.sv
// Result queue in front of the statistics channel.
`default_nettype none
`include "sample_state_histogram_core_defines.svh"

module sshist_obuf (
	input  logic                          clk,
	input  logic                          arst_n,
	input  logic                          push,
	input  sshist_pkg::stat_t             push_data,
	output logic [sshist_pkg::OBUF_CNT_W-1:0] cnt,
	sshist_stat_if.source                 stats
);
	import sshist_pkg::*;

	stat_t                 mem [OBUF_DEPTH];
	logic [OBUF_PTR_W-1:0] wr_q;
	logic [OBUF_PTR_W-1:0] rd_q;
	logic [OBUF_CNT_W-1:0] cnt_q;
	logic                  pop;
	stat_t                 head;

	assign pop  = stats.valid && stats.ready;
	assign cnt  = cnt_q;
	assign head = mem[rd_q];

	assign stats.valid        = (cnt_q != '0);
	assign stats.count_state0 = head.count_state0;
	assign stats.count_state1 = head.count_state1;
	assign stats.count_state2 = head.count_state2;
	assign stats.count_state3 = head.count_state3;
	assign stats.sample_total = head.sample_total;
	assign stats.packet_total = head.packet_total;

	always_ff @(posedge clk) begin
		if (push) begin
			mem[wr_q] <= push_data;
		end
	end

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			wr_q  <= '0;
			rd_q  <= '0;
			cnt_q <= '0;
		end else begin
			if (push) begin
				wr_q <= wr_q + 1'b1;
			end
			if (pop) begin
				rd_q <= rd_q + 1'b1;
			end
			case ({push, pop})
				2'b10:   cnt_q <= cnt_q + 1'b1;
				2'b01:   cnt_q <= cnt_q - 1'b1;
				default: cnt_q <= cnt_q;
			endcase
		end
	end

	`SSH_ASSERT_IMP(a_no_overflow, push, cnt_q < OBUF_CNT_W'(OBUF_DEPTH))
	`SSH_ASSERT_NXT(a_cnt_up, push && !pop, cnt_q == $past(cnt_q) + 1'b1)
	`SSH_ASSERT_NXT(a_cnt_down, pop && !push, cnt_q == $past(cnt_q) - 1'b1)

endmodule

`default_nettype wire

// File: dv/tb_sample_state_histogram_core.sv
// Self-checking testbench of the sample state histogram against a predictor.
`timescale 1ns / 1ps

module tb_sample_state_histogram_core;
	import sshist_pkg::*;

	localparam int CNT_W        = 48;
	localparam int SETTLE       = 8;
	localparam int HOLD_CYCLES  = 150;
	localparam int QUIET_LIMIT  = 2000;
	localparam int WORD_TARGET  = 450;
	localparam logic [63:0] CNT_MAX = (64'd1 << CNT_W) - 64'd1;

	logic clk;
	logic arst_n;

	sshist_word_if word_ch();
	sshist_stat_if stat_ch();
	sshist_cfg_if  cfg_ch();

	sample_state_histogram_core #(
		.COUNTER_WIDTH(CNT_W)
	) dut (
		.clk(clk),
		.arst_n(arst_n),
		.samples(word_ch.sink),
		.stats(stat_ch.source),
		.cfg(cfg_ch.sink)
	);

	mode_t        mode_q;
	logic [63:0]  mask_q;
	logic [6:0]   count_q;
	logic [63:0]  bin_cnt [NUM_STATES];
	logic [63:0]  samples_cnt;
	logic [31:0]  packets_cnt;
	stat_t        pending_totals [$];

	int  mismatches;
	int  quiet_cycles;
	int  words_sent;
	bit  gaps_on;
	bit  hold_tgl;

	initial begin
		clk = 1'b0;
		forever #5 clk = ~clk;
	end

	function automatic logic [63:0] sat_add(input logic [63:0] a, input logic [63:0] b);
		logic [63:0] base;
		base = (a > CNT_MAX) ? CNT_MAX : a;
		return (b > CNT_MAX - base) ? CNT_MAX : base + b;
	endfunction

	function automatic logic [STAT_W-1:0] clamp_out(input logic [63:0] v);
		return (v > 64'(STAT_MAX)) ? STAT_MAX : v[STAT_W-1:0];
	endfunction

	function automatic void absorb_word(input logic [63:0] w, input logic last);
		logic [63:0] hits [NUM_STATES];
		logic [1:0]  val;
		int          slots;
		stat_t       r;
		for (int i = 0; i < NUM_STATES; i++) hits[i] = '0;
		if (mode_q == MODE_ONE || mode_q == MODE_TWO) begin
			slots = (mode_q == MODE_TWO) ? SLOTS_TWO : SLOTS_ONE;
			for (int s = 0; s < slots; s++) begin
				if (count_q == 0 || mask_q[s]) begin
					val = (mode_q == MODE_TWO) ? w[2*s +: 2] : {1'b0, w[s]};
					hits[val]++;
				end
			end
			for (int i = 0; i < NUM_STATES; i++) bin_cnt[i] = sat_add(bin_cnt[i], hits[i]);
			samples_cnt = sat_add(samples_cnt, (count_q == 0) ? 64'(slots) : 64'(count_q));
		end
		if (last) begin
			if (packets_cnt != PKT_MAX) packets_cnt++;
			r.count_state0 = clamp_out(bin_cnt[0]);
			r.count_state1 = clamp_out(bin_cnt[1]);
			r.count_state2 = clamp_out(bin_cnt[2]);
			r.count_state3 = clamp_out(bin_cnt[3]);
			r.sample_total = clamp_out(samples_cnt);
			r.packet_total = packets_cnt;
			pending_totals.push_back(r);
		end
	endfunction

	task automatic check_field(input string name, input logic [63:0] want, input logic [63:0] got);
		if (want !== got) begin
			$error("%s: expected %0d, got %0d", name, want, got);
			mismatches++;
		end
	endtask

	always @(posedge clk) begin
		stat_t want;
		bit    moved;
		if (arst_n) begin
			moved = 1'b0;
			if (cfg_ch.valid && cfg_ch.ready) begin
				moved = 1'b1;
				case (cfg_reg_t'(cfg_ch.index))
					REG_BITS_PER_SAMPLE: mode_q = mode_t'(cfg_ch.data[MODE_W-1:0]);
					REG_SLOT_MASK: mask_q = cfg_ch.data;
					REG_CHANNEL_COUNT: count_q = cfg_ch.data[CHAN_W-1:0];
					default: ;
				endcase
			end
			if (word_ch.valid && word_ch.ready) begin
				moved = 1'b1;
				absorb_word(word_ch.data_word, word_ch.last_word);
			end
			if (stat_ch.valid && stat_ch.ready) begin
				moved = 1'b1;
				if (pending_totals.size() == 0) begin
					$error("statistics word with none expected");
					mismatches++;
				end else begin
					want = pending_totals.pop_front();
					check_field("count_state0", want.count_state0, stat_ch.count_state0);
					check_field("count_state1", want.count_state1, stat_ch.count_state1);
					check_field("count_state2", want.count_state2, stat_ch.count_state2);
					check_field("count_state3", want.count_state3, stat_ch.count_state3);
					check_field("sample_total", want.sample_total, stat_ch.sample_total);
					check_field("packet_total", want.packet_total, stat_ch.packet_total);
				end
			end
			quiet_cycles <= moved ? 0 : quiet_cycles + 1;
		end
	end

	initial begin
		int  stall_left;
		bit  hold_seen;
		stall_left = 0;
		hold_seen = 1'b0;
		stat_ch.ready <= 1'b0;
		@(posedge arst_n);
		forever begin
			@(posedge clk);
			if (hold_tgl != hold_seen) begin
				hold_seen = hold_tgl;
				stall_left = HOLD_CYCLES;
			end
			if (stall_left > 0) begin
				stall_left--;
				stat_ch.ready <= 1'b0;
			end else begin
				stat_ch.ready <= !(gaps_on && $urandom_range(99) < 26);
			end
		end
	end

	initial begin
		while (quiet_cycles < QUIET_LIMIT) @(posedge clk);
		$display("Regression FAIL");
		$finish;
	end

	function automatic logic [63:0] pick_word();
		case ($urandom_range(9))
			0: return '0;
			1: return '1;
			default: return {$urandom, $urandom};
		endcase
	endfunction

	task automatic send_word(input logic [63:0] w, input logic last);
		while (gaps_on && $urandom_range(99) < 26) begin
			word_ch.valid <= 1'b0;
			@(posedge clk);
		end
		word_ch.valid <= 1'b1;
		word_ch.data_word <= w;
		word_ch.last_word <= last;
		do @(posedge clk); while (!word_ch.ready);
		words_sent++;
	endtask

	task automatic stop_words();
		word_ch.valid <= 1'b0;
		@(posedge clk);
	endtask

	task automatic wait_drained();
		while (pending_totals.size() != 0) @(posedge clk);
	endtask

	task automatic write_reg(input cfg_reg_t idx, input logic [63:0] value);
		cfg_ch.valid <= 1'b1;
		cfg_ch.index <= idx;
		cfg_ch.data <= value;
		do @(posedge clk); while (!cfg_ch.ready);
	endtask

	// pad unused register bits with fill to check they are dropped
	task automatic configure(input mode_t m, input logic [63:0] mask, input logic [6:0] cnt,
		input logic [63:0] fill);
		stop_words();
		wait_drained();
		repeat (SETTLE) @(posedge clk);
		write_reg(REG_BITS_PER_SAMPLE, {fill[63:MODE_W], m});
		write_reg(REG_SLOT_MASK, mask);
		write_reg(REG_CHANNEL_COUNT, {fill[63:CHAN_W], cnt});
		cfg_ch.valid <= 1'b0;
		@(posedge clk);
	endtask

	task automatic test_default_two_bit();
		send_word(64'h0, 1'b1);
		send_word('1, 1'b1);
		send_word(64'h5555_5555_5555_5555, 1'b0);
		send_word(64'hAAAA_AAAA_AAAA_AAAA, 1'b1);
		send_word(64'h0123_4567_89AB_CDEF, 1'b0);
		send_word(64'hFEDC_BA98_7654_3210, 1'b1);
	endtask

	task automatic test_one_bit_and_packet_only();
		configure(MODE_ONE, '0, 7'd0, '0);
		send_word('1, 1'b1);
		send_word(64'hAAAA_AAAA_AAAA_AAAA, 1'b1);
		configure(MODE_NONE, '1, 7'd0, '0);
		send_word(pick_word(), 1'b0);
		send_word('1, 1'b1);
		configure(MODE_OFF, '0, 7'd64, '0);
		send_word(64'h9E37_79B9_7F4A_7C15, 1'b1);
	endtask

	task automatic test_channel_selection();
		configure(MODE_TWO, 64'hFFFF_FFFF_0000_0000, 7'd5, '0);
		send_word('1, 1'b1);
		configure(MODE_TWO, 64'h1, 7'd1, '0);
		send_word(64'h3, 1'b1);
		send_word(64'h2, 1'b1);
		configure(MODE_ONE, '1, 7'd64, '0);
		send_word(64'hAAAA_AAAA_AAAA_AAAA, 1'b1);
		configure(MODE_ONE, 64'h8000_0000_0000_0001, 7'd127, '0);
		send_word(64'h8000_0000_0000_0000, 1'b1);
		configure(MODE_TWO, '0, 7'd3, '1);
		send_word('1, 1'b1);
	endtask

	task automatic test_output_backpressure();
		configure(MODE_TWO, '0, 7'd0, '0);
		gaps_on = 1'b0;
		hold_tgl = ~hold_tgl;
		for (int i = 0; i < 40; i++) send_word(pick_word(), $urandom_range(3) != 0);
		stop_words();
		gaps_on = 1'b1;
	endtask

	task automatic test_drain_pause();
		configure(MODE_ONE, {$urandom, $urandom}, 7'd40, '0);
		for (int i = 0; i < 15; i++) send_word(pick_word(), $urandom_range(1));
		send_word(pick_word(), 1'b1);
		stop_words();
		wait_drained();
		for (int i = 0; i < 15; i++) send_word(pick_word(), $urandom_range(1));
		send_word(pick_word(), 1'b1);
	endtask

	task automatic test_random_packets();
		int          phase;
		int          len;
		logic [63:0] mask;
		logic [6:0]  cnt;
		phase = 0;
		while (words_sent < WORD_TARGET) begin
			case ($urandom_range(3))
				0: mask = '0;
				1: mask = '1;
				default: mask = {$urandom, $urandom};
			endcase
			case ($urandom_range(4))
				0: cnt = 7'd0;
				1: cnt = 7'd64;
				2: cnt = 7'd127;
				default: cnt = 7'($urandom_range(127));
			endcase
			configure(mode_t'($urandom_range(3)), mask, cnt, {$urandom, $urandom});
			gaps_on = !(phase >= 6 && phase < 12);
			repeat ($urandom_range(1, 5)) begin
				len = ($urandom_range(7) == 0) ? $urandom_range(5, 12) : $urandom_range(1, 4);
				for (int i = 1; i <= len; i++) send_word(pick_word(), i == len);
			end
			phase++;
		end
		gaps_on = 1'b1;
	endtask

	initial begin
		mismatches = 0;
		quiet_cycles = 0;
		words_sent = 0;
		gaps_on = 1'b1;
		hold_tgl = 1'b0;
		mode_q = MODE_TWO;
		mask_q = '0;
		count_q = '0;
		for (int i = 0; i < NUM_STATES; i++) bin_cnt[i] = '0;
		samples_cnt = '0;
		packets_cnt = '0;
		arst_n <= 1'b0;
		word_ch.valid <= 1'b0;
		word_ch.data_word <= '0;
		word_ch.last_word <= 1'b0;
		cfg_ch.valid <= 1'b0;
		cfg_ch.index <= REG_BITS_PER_SAMPLE;
		cfg_ch.data <= '0;
		repeat (8) @(posedge clk);
		arst_n <= 1'b1;
		repeat (SETTLE) @(posedge clk);

		test_default_two_bit();
		test_one_bit_and_packet_only();
		test_channel_selection();
		test_output_backpressure();
		test_drain_pause();
		test_random_packets();

		stop_words();
		wait_drained();
		repeat (SETTLE) @(posedge clk);
		if (mismatches == 0 && pending_totals.size() == 0) begin
			$display("Regression PASS");
		end else begin
			$display("Regression FAIL");
		end
		$finish;
	end

endmodule
